// ----- src/dtdss_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dtdss_pkg
// Shared types, segment codes and the digit glyph table for the dual
// three-digit seven-segment scanner.
// ----------------------------------------------------------------------------
package dtdss_pkg;

    // input transfer: two display values
    typedef struct packed {
        logic [15:0] first_value;
        logic [15:0] second_value;
    } t_in;

    // result transfer: lit digit and both segment buses
    typedef struct packed {
        logic [2:0] active_digit;
        logic [6:0] first_segments;
        logic [6:0] second_segments;
    } t_out;

    // decimal digits of one value, as seen by the segment logic
    typedef struct packed {
        logic [3:0] ones;
        logic [3:0] tens;
        logic [3:0] hundreds;
        logic       hundreds_lit;  // hundreds digit is 1..9
        logic       below_ten;     // value is 0..9
    } t_digits;

    // scan positions
    localparam logic [2:0] POS_ONE_ONES     = 3'd0;
    localparam logic [2:0] POS_ONE_TENS     = 3'd1;
    localparam logic [2:0] POS_ONE_HUNDREDS = 3'd2;
    localparam logic [2:0] POS_TWO_ONES     = 3'd3;
    localparam logic [2:0] POS_TWO_TENS     = 3'd4;
    localparam logic [2:0] POS_TWO_HUNDREDS = 3'd5;

    // segment patterns, bit6=a .. bit0=g
    localparam logic [6:0] SEG_BLANK = 7'h00;
    localparam logic [6:0] SEG_MINUS = 7'h01;
    localparam logic [6:0] SEG_O     = 7'h7E;
    localparam logic [6:0] SEG_L     = 7'h0E;

    localparam logic [15:0] OVERLOAD_VALUE = 16'hFFFF;

    // digit to segment pattern, anything above 9 is blank
    function automatic logic [6:0] glyph(input logic [3:0] d);
        logic [6:0] seg;
        case (d)
            4'd0:    seg = 7'h7E;
            4'd1:    seg = 7'h30;
            4'd2:    seg = 7'h6D;
            4'd3:    seg = 7'h79;
            4'd4:    seg = 7'h33;
            4'd5:    seg = 7'h5B;
            4'd6:    seg = 7'h5F;
            4'd7:    seg = 7'h72;
            4'd8:    seg = 7'h7F;
            4'd9:    seg = 7'h7B;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

endpackage
`default_nettype wire

// ----- src/dtdss_digits.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dtdss_digits
// Splits a 16-bit value into ones, tens and hundreds digits using
// reciprocal multiplies (divide by 10 and by 100), no dividers.
// ----------------------------------------------------------------------------
module dtdss_digits
    import dtdss_pkg::*;
(
    input  wire logic [15:0] i_value,
    output t_digits          o_digits
);

    logic [31:0] prod10;
    logic [26:0] prod100;
    logic [12:0] q10;
    logic [9:0]  q100;
    logic [15:0] ones_full;
    logic [12:0] tens_full;

    // v/10 = (v * 0xCCCD) >> 19, exact over 16 bits
    assign prod10 = 32'(i_value) * 32'd52429;
    assign q10    = prod10[31:19];

    // v/100 = (v>>2)/25 = ((v>>2) * 5243) >> 17, exact over 16 bits
    assign prod100 = 27'(i_value[15:2]) * 27'd5243;
    assign q100    = prod100[26:17];

    // remainders by shift-add times ten
    assign ones_full = i_value - ({3'b000, q10} << 3) - ({3'b000, q10} << 1);
    assign tens_full = q10 - ({3'b000, q100} << 3) - ({3'b000, q100} << 1);

    always_comb begin
        o_digits.ones         = ones_full[3:0];
        o_digits.tens         = tens_full[3:0];
        o_digits.hundreds     = q100[3:0];
        o_digits.hundreds_lit = (q100 != 10'd0) && (q100 <= 10'd9);
        o_digits.below_ten    = (q10 == 13'd0);
    end

endmodule
`default_nettype wire

// ----- src/dual_three_digit_seven_segment_scanner.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dual_three_digit_seven_segment_scanner
// Each transfer is one scan tick: steps a six-position scan index and
// refreshes the segment pattern of the digit now lit.
//
//  channel | direction | handshake                 | payload
//  in      | input     | i_in_valid / o_in_stall   | i_in_data  (t_in)
//  out     | output    | o_out_valid / i_out_stall | o_out_data (t_out)
//
// One item per cycle while the output is not stalled; each item passes
// the input register, then the result register.
// Synchronous active-low reset clears the scan index, both held patterns
// and all valid flags; the first tick lights position 1, display one tens.
// A stall on the output holds the result and backs up into the input
// register, which then stalls the input side.
// ----------------------------------------------------------------------------
module dual_three_digit_seven_segment_scanner
    import dtdss_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_out      o_out_data
);

    logic       r_in_valid;
    t_in        r_in;
    logic       r_out_valid;
    t_out       r_out;
    logic [2:0] r_scan_idx;
    logic [6:0] r_first_pat;
    logic [6:0] r_second_pat;

    logic       advance;
    logic       in_xfer;
    logic [2:0] n_scan_idx;
    logic [6:0] n_first_pat;
    logic [6:0] n_second_pat;
    logic [15:0] sel_value;
    logic        overload;
    t_digits     digits;

    // pipeline flow control
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_xfer    = i_in_valid && !o_in_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in <= i_in_data;
        end
    end

    // scan index step with wrap after the last position
    assign n_scan_idx = (r_scan_idx >= POS_TWO_HUNDREDS) ? POS_ONE_ONES
                                                         : r_scan_idx + 3'd1;

    // display two drops its sign bit before the digit split
    assign sel_value = (n_scan_idx < POS_TWO_ONES) ? r_in.first_value
                                                   : {1'b0, r_in.second_value[14:0]};
    assign overload  = (r_in.first_value == OVERLOAD_VALUE);

    dtdss_digits u_digits (
        .i_value  (sel_value),
        .o_digits (digits)
    );

    // pattern of the lit digit, the other display holds
    always_comb begin
        n_first_pat  = r_first_pat;
        n_second_pat = r_second_pat;
        case (n_scan_idx)
            POS_ONE_ONES: begin
                n_first_pat = overload ? SEG_L : glyph(digits.ones);
            end
            POS_ONE_TENS: begin
                if (overload) begin
                    n_first_pat = SEG_O;
                end else if (digits.below_ten) begin
                    n_first_pat = SEG_BLANK;
                end else begin
                    n_first_pat = glyph(digits.tens);
                end
            end
            POS_ONE_HUNDREDS: begin
                n_first_pat = (overload || !digits.hundreds_lit) ? SEG_BLANK
                                                                 : glyph(digits.hundreds);
            end
            POS_TWO_ONES: begin
                n_second_pat = glyph(digits.ones);
            end
            POS_TWO_TENS: begin
                n_second_pat = glyph(digits.tens);
            end
            default: begin
                if (r_in.second_value[15]) begin
                    n_second_pat = SEG_MINUS;
                end else if (!digits.hundreds_lit) begin
                    n_second_pat = SEG_BLANK;
                end else begin
                    n_second_pat = glyph(digits.hundreds);
                end
            end
        endcase
    end

    // scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_idx   <= POS_ONE_ONES;
            r_first_pat  <= SEG_BLANK;
            r_second_pat <= SEG_BLANK;
        end else if (advance) begin
            r_scan_idx   <= n_scan_idx;
            r_first_pat  <= n_first_pat;
            r_second_pat <= n_second_pat;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out.active_digit    <= n_scan_idx;
            r_out.first_segments  <= n_first_pat;
            r_out.second_segments <= n_second_pat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // checks
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.active_digit <= POS_TWO_HUNDREDS))
        else $error("active digit out of range");

    a_held_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in)))
        else $error("held input item lost or changed");

    a_second_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (n_scan_idx < POS_TWO_ONES)) |=> $stable(r_second_pat))
        else $error("display two pattern changed while display one scanned");

    a_first_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (n_scan_idx >= POS_TWO_ONES)) |=> $stable(r_first_pat))
        else $error("display one pattern changed while display two scanned");

endmodule
`default_nettype wire
